// File: rtl/core/stpm_pkg.sv
// Shared types, constants and helper functions for the stereo timestamp pair matcher.
// Depends on nothing; every other file of the block but stpm_ram imports it.
`timescale 1ns / 1ps

package stpm_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;

    // Field widths
    localparam int STAMP_W = 63;
    localparam int TAG_W   = 16;
    localparam int LIMIT_W = 5;
    localparam int LIM_CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;
    localparam logic [PADDR_W-3:0] REG_QUEUE_LIMIT = '0;

    typedef logic [STAMP_W-1:0] stamp_t;
    typedef logic [TAG_W-1:0]   tag_t;
    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [LIMIT_W-1:0] limit_t;

    typedef struct packed {
        stamp_t stamp;
        tag_t   tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_SHIFT  = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic search;
        logic shift;
        logic remove;
        logic append;
        logic emit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic hit;
        logic miss_done;
        logic shift_done;
        logic out_free;
    } ctrl_stat_t;

    // Circular index: base plus offset, offset at most QUEUE_DEPTH
    function automatic ptr_t wrap_add(ptr_t base, cnt_t off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(QUEUE_DEPTH))
        begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    // Clamp the programmed limit into 1 .. QUEUE_DEPTH
    function automatic cnt_t eff_limit(limit_t lim);
        logic [LIM_CMP_W-1:0] lim_x;
        cnt_t                 res;
        lim_x = LIM_CMP_W'(lim);
        if (lim_x == '0)
        begin
            res = CNT_W'(1);
        end
        else if (lim_x > LIM_CMP_W'(QUEUE_DEPTH))
        begin
            res = CNT_W'(QUEUE_DEPTH);
        end
        else
        begin
            res = CNT_W'(lim_x);
        end
        return res;
    endfunction

endpackage

// File: rtl/core/stpm_ifs.sv
// Valid/ready channel interfaces for frame items and matched pairs.
// Depends on stpm_pkg for the payload types.
`timescale 1ns / 1ps

interface stpm_item_if import stpm_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   side;
    stamp_t stamp;
    tag_t   frame_tag;

    modport source (output valid, output side, output stamp, output frame_tag, input ready);
    modport sink   (input valid, input side, input stamp, input frame_tag, output ready);
endinterface

interface stpm_pair_if import stpm_pkg::*; ();
    logic   valid;
    logic   ready;
    tag_t   left_tag;
    tag_t   right_tag;
    stamp_t pair_stamp;

    modport source (output valid, output left_tag, output right_tag, output pair_stamp,
                    input ready);
    modport sink   (input valid, input left_tag, input right_tag, input pair_stamp,
                    output ready);
endinterface

// File: rtl/core/stpm_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Self-contained; no package dependency.
`timescale 1ns / 1ps

module stpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/stpm_ctrl.sv
// Sequencing state machine: accept, search, then append on a miss or close the gap and emit on a hit.
// Depends on stpm_pkg for state, command and status types.
`timescale 1ns / 1ps

module stpm_ctrl import stpm_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (stat.hit)
                begin
                    cmd.search = 1'b1;
                    state_next = ST_SHIFT;
                end
                else if (stat.miss_done)
                begin
                    cmd.append = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.search = 1'b1;
                end
            end
            ST_SHIFT:
            begin
                if (stat.shift_done)
                begin
                    cmd.remove = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.shift = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

// File: rtl/core/stpm_datapath.sv
// Queue storage, pointers, search compare, gap closing and output register.
// Depends on stpm_pkg and instantiates stpm_ram once per side.
`timescale 1ns / 1ps

module stpm_datapath import stpm_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_cmd_t  cmd,
    output ctrl_stat_t stat,
    input  logic       in_side,
    input  stamp_t     in_stamp,
    input  tag_t       in_tag,
    input  limit_t     queue_limit,
    output logic       out_valid,
    input  logic       out_ready,
    output tag_t       out_left_tag,
    output tag_t       out_right_tag,
    output stamp_t     out_stamp
);

    // Current item
    logic   side_reg;
    stamp_t stamp_reg;
    tag_t   tag_reg;
    tag_t   other_tag_reg;

    // Per-side circular queue pointers
    ptr_t head_reg   [2];
    ptr_t head_next  [2];
    cnt_t count_reg  [2];
    cnt_t count_next [2];

    // Search pipeline
    cnt_t rd_idx_reg;
    cnt_t rd_idx_next;
    cnt_t cmp_idx_reg;
    cnt_t cmp_idx_next;
    logic cmp_valid_reg;
    logic cmp_valid_next;

    // Gap closing pipeline
    cnt_t sh_rd_reg;
    cnt_t sh_rd_next;
    cnt_t sh_wpos_reg;
    cnt_t sh_wpos_next;
    logic sh_wv_reg;
    logic sh_wv_next;

    // Output register
    logic   out_valid_reg;
    logic   out_valid_next;
    tag_t   out_left_reg;
    tag_t   out_right_reg;
    stamp_t out_stamp_reg;

    logic   oth;
    cnt_t   lim;
    cnt_t   own_cnt_in;
    cnt_t   trim_n;
    cnt_t   oth_cnt;
    entry_t rd_entry;
    logic   hit;
    ptr_t   ram_raddr;

    logic               ram_we    [2];
    ptr_t               ram_waddr [2];
    logic [ENTRY_W-1:0] ram_wdata [2];
    logic [ENTRY_W-1:0] ram_rdata [2];

    assign oth        = ~side_reg;
    assign lim        = eff_limit(queue_limit);
    assign own_cnt_in = count_reg[in_side];
    assign trim_n     = own_cnt_in - lim + CNT_W'(1);
    assign oth_cnt    = count_reg[oth];
    assign rd_entry   = entry_t'(ram_rdata[oth]);
    assign hit        = cmp_valid_reg && (rd_entry.stamp == stamp_reg);

    // Status to the controller
    assign stat.hit        = hit;
    assign stat.miss_done  = !cmp_valid_reg && (rd_idx_reg >= oth_cnt);
    assign stat.shift_done = !sh_wv_reg && (sh_rd_reg >= oth_cnt);
    assign stat.out_free   = !out_valid_reg || out_ready;

    // Next values of pointers, counters and pipelines
    always_comb
    begin
        head_next[0]   = head_reg[0];
        head_next[1]   = head_reg[1];
        count_next[0]  = count_reg[0];
        count_next[1]  = count_reg[1];
        rd_idx_next    = rd_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        sh_rd_next     = sh_rd_reg;
        sh_wpos_next   = sh_wpos_reg;
        sh_wv_next     = sh_wv_reg;

        // Drop the oldest own-side entries down to limit - 1
        if (cmd.load)
        begin
            if (own_cnt_in >= lim)
            begin
                head_next[in_side]  = wrap_add(head_reg[in_side], trim_n);
                count_next[in_side] = lim - CNT_W'(1);
            end
            rd_idx_next    = '0;
            cmp_valid_next = 1'b0;
        end

        // Read the opposite queue oldest first, compare the read data in the cycle after
        if (cmd.search)
        begin
            if (hit)
            begin
                cmp_valid_next = 1'b0;
                sh_rd_next     = cmp_idx_reg + CNT_W'(1);
                sh_wv_next     = 1'b0;
            end
            else if (rd_idx_reg < oth_cnt)
            begin
                rd_idx_next    = rd_idx_reg + CNT_W'(1);
                cmp_idx_next   = rd_idx_reg;
                cmp_valid_next = 1'b1;
            end
            else
            begin
                cmp_valid_next = 1'b0;
            end
        end

        // Move each later entry one place toward the head
        if (cmd.shift)
        begin
            if (sh_rd_reg < oth_cnt)
            begin
                sh_rd_next   = sh_rd_reg + CNT_W'(1);
                sh_wpos_next = sh_rd_reg - CNT_W'(1);
                sh_wv_next   = 1'b1;
            end
            else
            begin
                sh_wv_next = 1'b0;
            end
        end

        if (cmd.remove)
        begin
            count_next[oth] = oth_cnt - CNT_W'(1);
        end

        if (cmd.append && (count_reg[side_reg] < CNT_W'(QUEUE_DEPTH)))
        begin
            count_next[side_reg] = count_reg[side_reg] + CNT_W'(1);
        end

        // Hold the result until the transfer completes
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg[0]   <= '0;
            head_reg[1]   <= '0;
            count_reg[0]  <= '0;
            count_reg[1]  <= '0;
            rd_idx_reg    <= '0;
            cmp_idx_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            sh_rd_reg     <= '0;
            sh_wpos_reg   <= '0;
            sh_wv_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg[0]   <= head_next[0];
            head_reg[1]   <= head_next[1];
            count_reg[0]  <= count_next[0];
            count_reg[1]  <= count_next[1];
            rd_idx_reg    <= rd_idx_next;
            cmp_idx_reg   <= cmp_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            sh_rd_reg     <= sh_rd_next;
            sh_wpos_reg   <= sh_wpos_next;
            sh_wv_reg     <= sh_wv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            side_reg  <= in_side;
            stamp_reg <= in_stamp;
            tag_reg   <= in_tag;
        end
        if (cmd.search && hit)
        begin
            other_tag_reg <= rd_entry.tag;
        end
        if (cmd.emit)
        begin
            out_left_reg  <= side_reg ? other_tag_reg : tag_reg;
            out_right_reg <= side_reg ? tag_reg : other_tag_reg;
            out_stamp_reg <= stamp_reg;
        end
    end

    // Read address into the opposite queue
    assign ram_raddr = cmd.shift ? wrap_add(head_reg[oth], sh_rd_reg)
                                 : wrap_add(head_reg[oth], rd_idx_reg);

    // One RAM per side: append on a miss, close the gap on a hit
    for (genvar s = 0; s < 2; s++)
    begin : g_side
        assign ram_we[s]    = (cmd.append && (side_reg == 1'(s)))
                           || (cmd.shift && sh_wv_reg && (oth == 1'(s)));
        assign ram_waddr[s] = cmd.append ? wrap_add(head_reg[s], count_reg[s])
                                         : wrap_add(head_reg[s], sh_wpos_reg);
        assign ram_wdata[s] = cmd.append ? {stamp_reg, tag_reg} : ram_rdata[s];

        stpm_ram #(
            .WIDTH (ENTRY_W),
            .DEPTH (QUEUE_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we[s]),
            .waddr (ram_waddr[s]),
            .wdata (ram_wdata[s]),
            .raddr (ram_raddr),
            .rdata (ram_rdata[s])
        );
    end

    assign out_valid     = out_valid_reg;
    assign out_left_tag  = out_left_reg;
    assign out_right_tag = out_right_reg;
    assign out_stamp     = out_stamp_reg;

endmodule

// File: rtl/core/stereo_timestamp_pair_matcher.sv
// Stereo timestamp pair matcher: pairs left/right frames with equal timestamps.
// Flow: a frame that finds no partner in the opposite queue is appended to its own queue and
// frees the input; a frame that pairs closes the gap behind its partner and frees the input
// in the same cycle that its pair is presented.
// One frame in work at a time, one queue entry read per cycle; a result stall holds the input closed.
// Reset: both queues empty, queue_limit at 10; queue RAM contents are not cleared.
`timescale 1ns / 1ps

module stereo_timestamp_pair_matcher import stpm_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    stpm_item_if.sink          frames,
    stpm_pair_if.source        pairs,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    limit_t     queue_limit_reg;
    logic       limit_sel;
    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    // Register decode on the word address
    assign limit_sel = (paddr[PADDR_W-1:2] == REG_QUEUE_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_limit_reg <= LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready && limit_sel)
        begin
            queue_limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata = limit_sel ? PDATA_W'(queue_limit_reg) : '0;
    assign pready = 1'b1;

    stpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (frames.valid),
        .in_ready (frames.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    stpm_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_side       (frames.side),
        .in_stamp      (frames.stamp),
        .in_tag        (frames.frame_tag),
        .queue_limit   (queue_limit_reg),
        .out_valid     (pairs.valid),
        .out_ready     (pairs.ready),
        .out_left_tag  (pairs.left_tag),
        .out_right_tag (pairs.right_tag),
        .out_stamp     (pairs.pair_stamp)
    );

    // An accepted frame always starts the sequence
    a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (frames.valid && frames.ready) |-> cmd.load)
        else $error("frame transfer without load");

    // One frame at a time: input closes right after a transfer
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (frames.valid && frames.ready) |=> !frames.ready)
        else $error("input ready right after a transfer");

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!pairs.valid || pairs.ready))
        else $error("result overwritten before transfer");

    // A pair is emitted only after its gap was closed
    a_emit_after_remove: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> $past(cmd.remove) || $past(cmd.emit == 1'b0 && !cmd.load && !cmd.search))
        else $error("emit without preceding removal");

endmodule

// File: dv/tb_stereo_timestamp_pair_matcher.sv
// Self-checking testbench for the stereo timestamp pair matcher: a directed table, then
// random frame streams under several queue limits, checked by the table or a pairing model.
// Depends on stpm_pkg, the stpm_ifs channel interfaces and the matcher RTL.
`timescale 1ns / 1ps

module tb_stereo_timestamp_pair_matcher;
    import stpm_pkg::*;

    localparam logic   SIDE_LEFT       = 1'b0;
    localparam logic   SIDE_RIGHT      = 1'b1;
    localparam stamp_t STAMP_MAX       = '1;
    localparam int     SETTLE_CYCLES   = QUEUE_DEPTH + 8;
    localparam int     WATCHDOG_LIMIT  = 2000;
    localparam int     PRESSURE_CYCLES = 400;
    localparam int     ITEMS_PER_PHASE = 80;
    localparam int     NUM_PHASES      = 6;
    localparam int     MAX_WAIT        = 12;

    typedef struct packed {
        tag_t   left_tag;
        tag_t   right_tag;
        stamp_t pair_stamp;
    } pair_t;

    typedef enum logic [1:0] {
        ROW_FRAME,
        ROW_LIMIT
    } row_kind_t;

    // How a frame row gets its expectation
    typedef enum logic [1:0] {
        OUT_PREDICT,
        OUT_NONE,
        OUT_PAIR
    } row_out_t;

    typedef struct {
        row_kind_t kind;
        logic      side;
        stamp_t    stamp;
        tag_t      tag;
        row_out_t  outcome;
        tag_t      left_tag;
        tag_t      right_tag;
        limit_t    limit;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    stpm_item_if frames();
    stpm_pair_if pairs();

    stereo_timestamp_pair_matcher dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .frames  (frames),
        .pairs   (pairs),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Pairing model state: programmed limit and one queue of unmatched frames per side
    limit_t cfg_limit = LIMIT_RESET;
    entry_t unmatched[2][$];
    pair_t  pending_pairs[$];
    row_t   plan[$];
    int     errors = 0;
    int     send_calm = 0;
    int     take_calm = 0;
    bit     pressure_armed = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Wait before the next transfer; now and then a run of back-to-back transfers
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic stamp_t rand_stamp();
        return stamp_t'({$urandom(), $urandom()});
    endfunction

    // Trim the own side, then pair with the oldest equal stamp of the other side
    function automatic bit pair_frame(input logic side, input stamp_t stamp, input tag_t tag,
                                      output pair_t pr);
        int     own;
        int     other;
        int     lim;
        int     pos;
        entry_t e;
        own   = (side == SIDE_RIGHT) ? 1 : 0;
        other = 1 - own;
        lim   = int'(cfg_limit);
        if (lim < 1)
        begin
            lim = 1;
        end
        if (lim > QUEUE_DEPTH)
        begin
            lim = QUEUE_DEPTH;
        end
        while (unmatched[own].size() >= lim)
        begin
            unmatched[own].delete(0);
        end
        pos = -1;
        for (int i = 0; i < unmatched[other].size(); i++)
        begin
            if (pos < 0 && unmatched[other][i].stamp == stamp)
            begin
                pos = i;
            end
        end
        pr = '0;
        if (pos < 0)
        begin
            e.stamp = stamp;
            e.tag   = tag;
            unmatched[own].insert(unmatched[own].size(), e);
            return 1'b0;
        end
        e = unmatched[other][pos];
        unmatched[other].delete(pos);
        pr.left_tag   = (side == SIDE_RIGHT) ? e.tag : tag;
        pr.right_tag  = (side == SIDE_RIGHT) ? tag : e.tag;
        pr.pair_stamp = stamp;
        return 1'b1;
    endfunction

    function automatic void add_frame(input logic side, input stamp_t stamp, input tag_t tag,
                                      input row_out_t outcome, input tag_t left_tag,
                                      input tag_t right_tag);
        row_t r;
        r.kind      = ROW_FRAME;
        r.side      = side;
        r.stamp     = stamp;
        r.tag       = tag;
        r.outcome   = outcome;
        r.left_tag  = left_tag;
        r.right_tag = right_tag;
        r.limit     = '0;
        plan.insert(plan.size(), r);
    endfunction

    function automatic void add_limit(input limit_t value);
        row_t r;
        r.kind      = ROW_LIMIT;
        r.side      = SIDE_LEFT;
        r.stamp     = '0;
        r.tag       = '0;
        r.outcome   = OUT_NONE;
        r.left_tag  = '0;
        r.right_tag = '0;
        r.limit     = value;
        plan.insert(plan.size(), r);
    endfunction

    // Offer one frame, hold it until the transfer, then record what it should produce
    task automatic send_frame(input logic side, input stamp_t stamp, input tag_t tag,
                              input row_out_t outcome, input tag_t left_tag,
                              input tag_t right_tag);
        int    gap;
        bit    hit;
        pair_t pr;
        gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            frames.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frames.valid     <= 1'b1;
        frames.side      <= side;
        frames.stamp     <= stamp;
        frames.frame_tag <= tag;
        do @(posedge clk); while (!frames.ready);
        hit = pair_frame(side, stamp, tag, pr);
        case (outcome)
            OUT_PREDICT:
            begin
                if (hit)
                begin
                    pending_pairs.insert(pending_pairs.size(), pr);
                end
            end
            OUT_PAIR:
            begin
                pr.left_tag   = left_tag;
                pr.right_tag  = right_tag;
                pr.pair_stamp = stamp;
                pending_pairs.insert(pending_pairs.size(), pr);
            end
            default:
            begin
            end
        endcase
    endtask

    // Drain: stop offering, wait for every pair, then let a frame still in work finish
    task automatic settle();
        frames.valid <= 1'b0;
        while (pending_pairs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic write, input limit_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {REG_QUEUE_LIMIT, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (!write && prdata !== PDATA_W'(value))
        begin
            errors++;
            $display("%0t: queue_limit readback mismatch, expected %0d, actual %0d",
                     $time, value, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Program the limit, mirror it in the model and read it back
    task automatic set_limit(input limit_t value);
        apb_access(1'b1, value);
        cfg_limit = value;
        apb_access(1'b0, value);
    endtask

    // Result side: random stalls, one long hold once armed, check every transfer
    initial
    begin
        int    hold;
        bit    pressure_done;
        pair_t want;
        hold          = 0;
        pressure_done = 1'b0;
        pairs.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pairs.valid && pairs.ready)
            begin
                if (pending_pairs.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected pair, expected none, actual %h/%h @ %h",
                             $time, pairs.left_tag, pairs.right_tag, pairs.pair_stamp);
                end
                else
                begin
                    want = pending_pairs[0];
                    pending_pairs.delete(0);
                    if (pairs.left_tag !== want.left_tag)
                    begin
                        errors++;
                        $display("%0t: left_tag mismatch, expected %h, actual %h",
                                 $time, want.left_tag, pairs.left_tag);
                    end
                    if (pairs.right_tag !== want.right_tag)
                    begin
                        errors++;
                        $display("%0t: right_tag mismatch, expected %h, actual %h",
                                 $time, want.right_tag, pairs.right_tag);
                    end
                    if (pairs.pair_stamp !== want.pair_stamp)
                    begin
                        errors++;
                        $display("%0t: pair_stamp mismatch, expected %h, actual %h",
                                 $time, want.pair_stamp, pairs.pair_stamp);
                    end
                end
                hold = draw_wait(take_calm);
                if (pressure_armed && !pressure_done)
                begin
                    hold          = PRESSURE_CYCLES;
                    pressure_done = 1'b1;
                end
                if (hold > 0)
                begin
                    pairs.ready <= 1'b0;
                end
            end
            else if (!pairs.ready)
            begin
                if (hold > 0)
                begin
                    hold--;
                end
                if (hold == 0)
                begin
                    pairs.ready <= 1'b1;
                end
            end
        end
    end

    // Watchdog: end the run if nothing transfers for too long
    initial
    begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((frames.valid && frames.ready) || (pairs.valid && pairs.ready)
                || (psel && penable))
            begin
                idle = 0;
            end
            else
            begin
                idle++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus
    initial
    begin
        limit_t phase_limits[NUM_PHASES];
        stamp_t cursor;
        stamp_t stamp;

        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        frames.valid     <= 1'b0;
        frames.side      <= SIDE_LEFT;
        frames.stamp     <= '0;
        frames.frame_tag <= '0;

        // Extremes of stamp and tag on both sides
        add_frame(SIDE_LEFT, '0, 16'h0000, OUT_NONE, '0, '0);
        add_frame(SIDE_RIGHT, '0, 16'hFFFF, OUT_PAIR, 16'h0000, 16'hFFFF);
        add_frame(SIDE_LEFT, STAMP_MAX, 16'hFFFF, OUT_NONE, '0, '0);
        add_frame(SIDE_RIGHT, STAMP_MAX, 16'h0000, OUT_PAIR, 16'hFFFF, 16'h0000);
        // Equal stamps on one side stay separate and pair oldest first
        add_frame(SIDE_LEFT, 63'd100, 16'h0011, OUT_NONE, '0, '0);
        add_frame(SIDE_LEFT, 63'd100, 16'h0022, OUT_NONE, '0, '0);
        add_frame(SIDE_RIGHT, 63'd100, 16'h00AA, OUT_PAIR, 16'h0011, 16'h00AA);
        add_frame(SIDE_RIGHT, 63'd100, 16'h00BB, OUT_PAIR, 16'h0022, 16'h00BB);
        // Right frame first
        add_frame(SIDE_RIGHT, 63'd200, 16'h1234, OUT_NONE, '0, '0);
        add_frame(SIDE_LEFT, 63'd200, 16'h4321, OUT_PAIR, 16'h4321, 16'h1234);
        // Hits in the middle and at the ends of the other queue
        add_frame(SIDE_RIGHT, 63'd301, 16'hA001, OUT_NONE, '0, '0);
        add_frame(SIDE_RIGHT, 63'd302, 16'hA002, OUT_NONE, '0, '0);
        add_frame(SIDE_RIGHT, 63'd303, 16'hA003, OUT_NONE, '0, '0);
        add_frame(SIDE_LEFT, 63'd302, 16'hB002, OUT_PREDICT, '0, '0);
        add_frame(SIDE_LEFT, 63'd303, 16'hB003, OUT_PREDICT, '0, '0);
        add_frame(SIDE_LEFT, 63'd301, 16'hB001, OUT_PREDICT, '0, '0);
        // Limit of two: drop the oldest own entry, also on a hit
        add_limit(5'd2);
        add_frame(SIDE_LEFT, 63'd500, 16'hC500, OUT_NONE, '0, '0);
        add_frame(SIDE_LEFT, 63'd501, 16'hC501, OUT_NONE, '0, '0);
        add_frame(SIDE_LEFT, 63'd502, 16'hC502, OUT_NONE, '0, '0);
        add_frame(SIDE_RIGHT, 63'd500, 16'hD500, OUT_NONE, '0, '0);
        add_frame(SIDE_RIGHT, 63'd501, 16'hD501, OUT_PAIR, 16'hC501, 16'hD501);
        add_frame(SIDE_RIGHT, 63'd600, 16'hD600, OUT_NONE, '0, '0);
        add_frame(SIDE_RIGHT, 63'd502, 16'hD502, OUT_PREDICT, '0, '0);

        // Limits for the random phases: top, bottom, both out-of-range codes, two in between
        phase_limits[0] = 5'd16;
        phase_limits[1] = 5'd1;
        phase_limits[2] = 5'd31;
        phase_limits[3] = 5'd0;
        phase_limits[4] = 5'd4;
        phase_limits[5] = limit_t'($urandom_range(2, 15));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_access(1'b0, LIMIT_RESET);

        // Walk the directed table
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_LIMIT)
            begin
                settle();
                set_limit(plan[i].limit);
            end
            else
            begin
                send_frame(plan[i].side, plan[i].stamp, plan[i].tag, plan[i].outcome,
                           plan[i].left_tag, plan[i].right_tag);
            end
        end

        // Random streams: mostly stamps near a moving cursor so both sides pair up,
        // with some full-range noise that stays unmatched
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            set_limit(phase_limits[p]);
            case (p % 3)
                0:       cursor = '0;
                1:       cursor = rand_stamp();
                default: cursor = STAMP_MAX - 63'd200;
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (p == 2 && n == 20)
                begin
                    pressure_armed = 1'b1;
                end
                if ($urandom_range(0, 4) == 0)
                begin
                    stamp = rand_stamp();
                end
                else
                begin
                    stamp = cursor + stamp_t'($urandom_range(0, 3));
                    if ($urandom_range(0, 1) == 1)
                    begin
                        cursor = cursor + 63'd1;
                    end
                end
                send_frame(logic'($urandom_range(0, 1)), stamp, tag_t'($urandom()),
                           OUT_PREDICT, '0, '0);
            end
        end

        settle();
        if (errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
